### design/tfm_pkg.sv
// tfm_pkg: shared types, constants and helper functions for the thruster force mixer
// no dependencies; used by tfm_vert and thruster_force_mixer
`default_nettype none

package tfm_pkg;

    localparam int HORIZONTAL_COUNT = 4;
    localparam int VERT_COUNT       = 2;
    localparam int REG_COUNT        = 4;
    localparam int REG_W            = 24;
    localparam int CFG_INDEX_W      = 2;
    localparam int PULSE_W          = 11;
    localparam int FORCE_W          = 8;
    localparam int RANGE_W          = 8;
    localparam int DIV_W            = RANGE_W + 1;
    localparam int QUO_W            = 11;
    localparam int BIT_W            = 4;
    localparam int MAP_W            = 13;
    localparam int ROW_SPLIT        = 2;

    localparam logic MODE_HORIZ = 1'b0;
    localparam logic MODE_VERT  = 1'b1;

    localparam logic [PULSE_W-1:0] PULSE_NEUTRAL = 11'd1500;
    localparam logic [PULSE_W-1:0] PULSE_MIN     = 11'd1000;
    localparam logic [PULSE_W-1:0] PULSE_MAX     = 11'd2000;
    localparam logic [PULSE_W-1:0] DEAD_UP       = 11'd1750;
    localparam logic [PULSE_W-1:0] DEAD_DOWN     = 11'd1250;

    localparam logic signed [MAP_W-1:0] MAP_HIGH  = 13'sd1850;
    localparam logic signed [MAP_W-1:0] MAP_LOW   = 13'sd1150;
    localparam logic signed [MAP_W-1:0] CLAMP_MIN = 13'sd1000;
    localparam logic signed [MAP_W-1:0] CLAMP_MAX = 13'sd2000;

    // span of the pulse map, 1850 - 1150
    localparam logic signed [10:0] MAP_SPAN = 11'sd700;

    localparam logic [QUO_W-1:0] QUO_SAT = {QUO_W{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_ABS,
        S_SCALE,
        S_DCHK,
        S_DIV,
        S_WRITE,
        S_PUSH
    } t_state;

    // full-scale range keyed by which demands are nonzero: {moment, y, x}
    function automatic logic [RANGE_W-1:0] range_of(input logic [2:0] nz);
        logic [RANGE_W-1:0] r;
        unique case (nz)
            3'b001:  r = 8'd64;
            3'b010:  r = 8'd36;
            3'b100:  r = 8'd152;
            3'b011:  r = 8'd50;
            3'b101:  r = 8'd108;
            3'b110:  r = 8'd95;
            3'b111:  r = 8'd84;
            default: r = 8'd36;
        endcase
        return r;
    endfunction

    function automatic logic [PULSE_W-1:0] clamp_s(input logic signed [MAP_W-1:0] v);
        logic [PULSE_W-1:0] r;
        if (v < CLAMP_MIN) begin
            r = PULSE_MIN;
        end else if (v > CLAMP_MAX) begin
            r = PULSE_MAX;
        end else begin
            r = v[PULSE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [PULSE_W-1:0] deadband(input logic [PULSE_W-1:0] p);
        logic [PULSE_W-1:0] r;
        if (p > PULSE_NEUTRAL && p < DEAD_UP) begin
            r = DEAD_UP;
        end else if (p < PULSE_NEUTRAL && p > DEAD_DOWN) begin
            r = DEAD_DOWN;
        end else if (p < PULSE_MIN) begin
            r = PULSE_MIN;
        end else if (p > PULSE_MAX) begin
            r = PULSE_MAX;
        end else begin
            r = p;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### design/thruster_force_mixer.sv
// thruster_force_mixer: top level, sequencer around one shared multiplier and a divide step
// depends on tfm_pkg and tfm_vert
//
// Keeps six thruster pulse widths (reset 1500) and sends all six as one output beat
// after every command. A vertical command is shaped combinationally and registered at
// the input beat, then copied to the output register once that register is free. A
// horizontal command walks the four rows through one shared multiplier and a
// one-bit-per-cycle restoring divider: per row three multiply-accumulate steps, then
// sign/magnitude, scale, saturation check, the divide when the quotient does not
// saturate, and write-back. The input is not ready while a command is in work; a
// finished result waits in its own output register, so the next command can be taken
// before that beat is consumed. Gains are to be written through the plain write port
// only while the block is idle; the block itself does not enforce this.
`default_nettype none

module thruster_force_mixer #(
    parameter int GAIN_WIDTH = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,

    input  wire logic                                i_cfg_we,
    input  wire logic [tfm_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire logic [tfm_pkg::REG_W-1:0]           i_cfg_data,

    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic                                i_mode,
    input  wire logic signed [tfm_pkg::FORCE_W-1:0]  i_force_x,
    input  wire logic signed [tfm_pkg::FORCE_W-1:0]  i_force_y,
    input  wire logic signed [tfm_pkg::FORCE_W-1:0]  i_turn_moment,
    input  wire logic [tfm_pkg::PULSE_W-1:0]         i_vert_first_pulse,
    input  wire logic [tfm_pkg::PULSE_W-1:0]         i_vert_second_pulse,

    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [tfm_pkg::PULSE_W-1:0]              o_pulse_h0,
    output logic [tfm_pkg::PULSE_W-1:0]              o_pulse_h1,
    output logic [tfm_pkg::PULSE_W-1:0]              o_pulse_h2,
    output logic [tfm_pkg::PULSE_W-1:0]              o_pulse_h3,
    output logic [tfm_pkg::PULSE_W-1:0]              o_pulse_v0,
    output logic [tfm_pkg::PULSE_W-1:0]              o_pulse_v1
);

    localparam int HC    = tfm_pkg::HORIZONTAL_COUNT;
    localparam int ROW_W = $clog2(HC);
    localparam int SW    = GAIN_WIDTH + 10;
    localparam int PW    = SW + 11;
    localparam int NW    = SW + 10;
    localparam int RW    = tfm_pkg::DIV_W + tfm_pkg::QUO_W;
    localparam int GWIDE = (3 * GAIN_WIDTH > tfm_pkg::REG_W) ? 3 * GAIN_WIDTH : tfm_pkg::REG_W;
    localparam int PLW   = tfm_pkg::PULSE_W;

    tfm_pkg::t_state r_state, n_state;

    logic [tfm_pkg::REG_W-1:0]          r_gain [tfm_pkg::REG_COUNT];

    logic signed [tfm_pkg::FORCE_W-1:0] r_force [3];
    logic signed [tfm_pkg::FORCE_W-1:0] n_force [3];
    logic [tfm_pkg::RANGE_W-1:0]        r_range, n_range;
    logic [ROW_W-1:0]                   r_row, n_row;
    logic [1:0]                         r_k, n_k;
    logic signed [SW-1:0]               r_acc, n_acc;
    logic                               r_neg, n_neg;
    logic [NW-1:0]                      r_num, n_num;
    logic [RW-1:0]                      r_rem, n_rem;
    logic [tfm_pkg::QUO_W-1:0]          r_quo, n_quo;
    logic [tfm_pkg::BIT_W-1:0]          r_bit, n_bit;

    logic [PLW-1:0] r_pulse_h [HC];
    logic [PLW-1:0] n_pulse_h [HC];
    logic [PLW-1:0] r_pulse_v [tfm_pkg::VERT_COUNT];
    logic [PLW-1:0] n_pulse_v [tfm_pkg::VERT_COUNT];
    logic [PLW-1:0] r_out_h   [HC];
    logic [PLW-1:0] n_out_h   [HC];
    logic [PLW-1:0] r_out_v   [tfm_pkg::VERT_COUNT];
    logic [PLW-1:0] n_out_v   [tfm_pkg::VERT_COUNT];
    logic           r_out_valid, n_out_valid;

    logic [PLW-1:0] vert_first, vert_second;

    // shared multiplier
    logic [GWIDE-1:0]                   gain_vec;
    logic signed [GAIN_WIDTH-1:0]       gain_sel;
    logic signed [tfm_pkg::FORCE_W-1:0] force_sel;
    logic signed [SW-1:0]               mul_a;
    logic signed [10:0]                 mul_b;
    logic signed [PW-1:0]               mul_p;

    logic signed [SW-1:0]               t_sum;
    logic [NW-1:0]                      sat_lim;
    logic [RW-1:0]                      trial;
    logic signed [tfm_pkg::MAP_W-1:0]   base;
    logic signed [tfm_pkg::MAP_W-1:0]   quo_s;
    logic signed [tfm_pkg::MAP_W-1:0]   mapped;
    logic                               in_beat;

    tfm_vert u_vert (
        .i_first  (i_vert_first_pulse),
        .i_second (i_vert_second_pulse),
        .o_first  (vert_first),
        .o_second (vert_second)
    );

    assign gain_vec = GWIDE'(r_gain[r_row]);
    assign gain_sel = gain_vec[r_k*GAIN_WIDTH +: GAIN_WIDTH];

    always_comb begin
        case (r_k)
            2'd0:    force_sel = r_force[0];
            2'd1:    force_sel = r_force[1];
            2'd2:    force_sel = r_force[2];
            default: force_sel = '0;
        endcase
    end

    always_comb begin
        if (r_state == tfm_pkg::S_SCALE) begin
            mul_a = r_acc;
            mul_b = tfm_pkg::MAP_SPAN;
        end else begin
            mul_a = SW'(gain_sel);
            mul_b = 11'(force_sel);
        end
    end

    assign mul_p   = PW'(mul_a) * PW'(mul_b);
    assign t_sum   = r_acc + $signed(SW'({1'b0, r_range}));
    assign sat_lim = NW'({r_range, 1'b0}) << tfm_pkg::QUO_W;
    assign trial   = RW'({r_range, 1'b0}) << r_bit;
    assign base    = (r_row < ROW_W'(tfm_pkg::ROW_SPLIT)) ? tfm_pkg::MAP_HIGH : tfm_pkg::MAP_LOW;
    assign quo_s   = $signed({2'b00, r_quo});
    assign mapped  = r_neg ? (base - quo_s) : (base + quo_s);
    assign in_beat = i_in_valid && o_in_ready;

    assign o_in_ready = (r_state == tfm_pkg::S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_force     = r_force;
        n_range     = r_range;
        n_row       = r_row;
        n_k         = r_k;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_num       = r_num;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_bit       = r_bit;
        n_pulse_h   = r_pulse_h;
        n_pulse_v   = r_pulse_v;
        n_out_h     = r_out_h;
        n_out_v     = r_out_v;
        n_out_valid = r_out_valid && !i_out_ready;

        unique case (r_state)
            tfm_pkg::S_IDLE: begin
                if (in_beat) begin
                    if (i_mode == tfm_pkg::MODE_VERT) begin
                        n_pulse_v[0] = vert_first;
                        n_pulse_v[1] = vert_second;
                        n_state      = tfm_pkg::S_PUSH;
                    end else begin
                        n_force[0] = i_force_x;
                        n_force[1] = i_force_y;
                        n_force[2] = i_turn_moment;
                        n_range    = tfm_pkg::range_of({i_turn_moment != '0,
                                                        i_force_y != '0,
                                                        i_force_x != '0});
                        n_row      = '0;
                        n_k        = '0;
                        n_acc      = '0;
                        n_state    = tfm_pkg::S_MAC;
                    end
                end
            end
            tfm_pkg::S_MAC: begin
                n_acc = r_acc + $signed(mul_p[SW-1:0]);
                if (r_k == 2'd2) begin
                    n_state = tfm_pkg::S_ABS;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            tfm_pkg::S_ABS: begin
                n_neg   = t_sum[SW-1] ^ (r_row < ROW_W'(tfm_pkg::ROW_SPLIT));
                n_acc   = t_sum[SW-1] ? -t_sum : t_sum;
                n_state = tfm_pkg::S_SCALE;
            end
            tfm_pkg::S_SCALE: begin
                n_num   = mul_p[NW-1:0];
                n_state = tfm_pkg::S_DCHK;
            end
            tfm_pkg::S_DCHK: begin
                if (r_num >= sat_lim) begin
                    n_quo   = tfm_pkg::QUO_SAT;
                    n_state = tfm_pkg::S_WRITE;
                end else begin
                    n_rem   = r_num[RW-1:0];
                    n_quo   = '0;
                    n_bit   = tfm_pkg::BIT_W'(tfm_pkg::QUO_W - 1);
                    n_state = tfm_pkg::S_DIV;
                end
            end
            tfm_pkg::S_DIV: begin
                if (r_rem >= trial) begin
                    n_rem        = r_rem - trial;
                    n_quo[r_bit] = 1'b1;
                end
                if (r_bit == '0) begin
                    n_state = tfm_pkg::S_WRITE;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            tfm_pkg::S_WRITE: begin
                n_pulse_h[r_row] = tfm_pkg::clamp_s(mapped);
                if (r_row == ROW_W'(HC - 1)) begin
                    n_state = tfm_pkg::S_PUSH;
                end else begin
                    n_row   = r_row + 1'b1;
                    n_k     = '0;
                    n_acc   = '0;
                    n_state = tfm_pkg::S_MAC;
                end
            end
            tfm_pkg::S_PUSH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_h     = r_pulse_h;
                    n_out_v     = r_pulse_v;
                    n_out_valid = 1'b1;
                    n_state     = tfm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tfm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tfm_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < HC; i++) begin
                r_pulse_h[i] <= tfm_pkg::PULSE_NEUTRAL;
            end
            for (int i = 0; i < tfm_pkg::VERT_COUNT; i++) begin
                r_pulse_v[i] <= tfm_pkg::PULSE_NEUTRAL;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pulse_h   <= n_pulse_h;
            r_pulse_v   <= n_pulse_v;
        end
    end

    // working registers and output payload
    always_ff @(posedge i_clk) begin
        r_force <= n_force;
        r_range <= n_range;
        r_row   <= n_row;
        r_k     <= n_k;
        r_acc   <= n_acc;
        r_neg   <= n_neg;
        r_num   <= n_num;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_bit   <= n_bit;
        r_out_h <= n_out_h;
        r_out_v <= n_out_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tfm_pkg::REG_COUNT; i++) begin
                r_gain[i] <= '0;
            end
        end else if (i_cfg_we) begin
            r_gain[i_cfg_index] <= i_cfg_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pulse_h0  = r_out_h[0];
    assign o_pulse_h1  = r_out_h[1];
    assign o_pulse_h2  = r_out_h[2];
    assign o_pulse_h3  = r_out_h[3];
    assign o_pulse_v0  = r_out_v[0];
    assign o_pulse_v1  = r_out_v[1];

endmodule

`default_nettype wire

### design/tfm_vert.sv
// tfm_vert: vertical pulse shaping, neutral override and deadband push with saturation
// depends on tfm_pkg
`default_nettype none

module tfm_vert (
    input  wire logic [tfm_pkg::PULSE_W-1:0] i_first,
    input  wire logic [tfm_pkg::PULSE_W-1:0] i_second,
    output logic      [tfm_pkg::PULSE_W-1:0] o_first,
    output logic      [tfm_pkg::PULSE_W-1:0] o_second
);

    always_comb begin
        if (i_first == tfm_pkg::PULSE_NEUTRAL) begin
            o_first  = tfm_pkg::PULSE_NEUTRAL;
            o_second = tfm_pkg::PULSE_NEUTRAL;
        end else begin
            o_first  = tfm_pkg::deadband(i_first);
            o_second = tfm_pkg::deadband(i_second);
        end
    end

endmodule

`default_nettype wire
